>>> rtl/core/cftp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cftp_pkg - shared types and constants for the CAN frame text parser
// Parser phases, character codes, limits and the hex digit decoder.
// ----------------------------------------------------------------------------
package cftp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_ID     = 3'd0,   // reading identifier digits
        PH_DSTART = 3'd1,   // just after '#'
        PH_REMOTE = 3'd2,   // after 'R', optional length digit may follow
        PH_RLEN   = 3'd3,   // remote length taken, nothing more allowed
        PH_DATA   = 3'd4    // reading data digits and dots
    } t_phase;

    // Hex decode result: valid flag and nibble value
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    // Character codes
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UC_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UC_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_UC_R  = 8'h52;  // 'R'
    localparam logic [7:0] CH_LC_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LC_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_LC_R  = 8'h72;  // 'r'

    // Limits
    localparam logic [3:0]  MAX_ID_CHARS   = 4'd8;
    localparam logic [3:0]  STD_ID_CHARS   = 4'd3;
    localparam logic [31:0] STD_ID_MAX     = 32'h0000_07FF;
    localparam logic [3:0]  MAX_DATA_BYTES = 4'd8;

    // Widths of the result fields
    localparam int unsigned ID_W      = 32;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned OUT_DW    = 104;  // ID_W + LEN_W + PAYLOAD_W, padded to bytes
    localparam int unsigned OUT_UW    = 3;

    // Decode one ASCII character as a hex digit
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.valid = 1'b0;
        r.value = 4'h0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.valid = 1'b1;
            r.value = 4'(c - CH_ZERO);
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            r.valid = 1'b1;
            r.value = 4'(c - CH_UC_A + 8'd10);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            r.valid = 1'b1;
            r.value = 4'(c - CH_LC_A + 8'd10);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/can_frame_text_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_text_parser_top - CAN frame text parser
// Parses id#data or id#R[len] text, one character per item, into one frame.
// ----------------------------------------------------------------------------
// A character is taken each cycle unless stalled. Each character updates the
// parser state in the same cycle; on the character marked by tlast the finished
// frame is loaded into the result register and appears on the master side in
// the next cycle, while the parser is already back in its start state for the
// next text. The slave side stalls only while a result sits unread in the result
// register, so throughput is one character per cycle whenever the consumer
// keeps up. A bad text gives one result with frame_ok low and all fields zero.
// ----------------------------------------------------------------------------
module can_frame_text_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Character stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,    // [7:0] char_in
    input  logic         s_axis_tlast,    // last_char
    // Frame result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,    // [31:0] frame_id, [35:32] data_length,
                                          // [99:36] payload, [103:100] zero
    output logic [2:0]   m_axis_tuser     // [0] frame_ok, [1] extended_id,
                                          // [2] remote_request
);

    // Parser state
    cftp_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_id, n_id;
    logic [3:0]       r_pc, n_pc;         // id characters seen
    logic [3:0]       r_bc, n_bc;         // data bytes stored
    logic [63:0]      r_payload, n_payload;
    logic [3:0]       r_pend, n_pend;     // high nibble waiting for its partner
    logic             r_nw, n_nw;
    logic             r_tok, n_tok;       // current token holds a digit
    logic [3:0]       r_rlen, n_rlen;
    logic             r_err, n_err;

    // Result register
    logic             r_out_valid;
    logic [103:0]     r_out_data;
    logic [2:0]       r_out_user;

    logic             in_fire;
    logic             end_fire;
    cftp_pkg::t_hex   hx;
    logic             v_data;
    logic             v_put;
    logic [7:0]       v_byte;
    logic             v_err;

    logic             res_err;
    logic             res_remote;
    logic             res_ext;
    logic [3:0]       res_len;
    logic [63:0]      res_payload;
    logic [31:0]      res_id;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign end_fire      = in_fire && s_axis_tlast;
    assign hx            = cftp_pkg::hex_decode(s_axis_tdata);

    // Next parser state for the character on the input
    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_pc      = r_pc;
        n_bc      = r_bc;
        n_payload = r_payload;
        n_pend    = r_pend;
        n_nw      = r_nw;
        n_tok     = r_tok;
        n_rlen    = r_rlen;
        v_err     = r_err;
        v_data    = 1'b0;
        v_put     = 1'b0;
        v_byte    = 8'h00;

        if (in_fire && !r_err) begin
            case (r_phase)
                cftp_pkg::PH_ID: begin
                    if (s_axis_tdata == cftp_pkg::CH_HASH) begin
                        if (r_pc == 4'd0) v_err = 1'b1;
                        else n_phase = cftp_pkg::PH_DSTART;
                    end else if (!hx.valid || r_pc >= cftp_pkg::MAX_ID_CHARS) begin
                        v_err = 1'b1;
                    end else begin
                        n_id = {r_id[27:0], hx.value};
                        n_pc = r_pc + 4'd1;
                    end
                end
                cftp_pkg::PH_DSTART: begin
                    if (s_axis_tdata == cftp_pkg::CH_UC_R ||
                        s_axis_tdata == cftp_pkg::CH_LC_R) begin
                        n_phase = cftp_pkg::PH_REMOTE;
                    end else begin
                        n_phase = cftp_pkg::PH_DATA;
                        v_data  = 1'b1;
                    end
                end
                cftp_pkg::PH_DATA: begin
                    v_data = 1'b1;
                end
                cftp_pkg::PH_REMOTE: begin
                    if (s_axis_tdata inside {[cftp_pkg::CH_ZERO:cftp_pkg::CH_EIGHT]}) begin
                        n_rlen  = 4'(s_axis_tdata - cftp_pkg::CH_ZERO);
                        n_phase = cftp_pkg::PH_RLEN;
                    end else begin
                        v_err = 1'b1;
                    end
                end
                default: begin
                    v_err = 1'b1;
                end
            endcase

            // Data digits and token separators
            if (v_data) begin
                if (s_axis_tdata == cftp_pkg::CH_DOT) begin
                    if (!r_tok) begin
                        v_err = 1'b1;
                    end else begin
                        if (r_nw) begin
                            v_put  = 1'b1;
                            v_byte = {4'h0, r_pend};
                            n_nw   = 1'b0;
                        end
                        n_tok = 1'b0;
                    end
                end else if (!hx.valid) begin
                    v_err = 1'b1;
                end else begin
                    n_tok = 1'b1;
                    if (r_nw) begin
                        v_put  = 1'b1;
                        v_byte = {r_pend, hx.value};
                        n_nw   = 1'b0;
                    end else begin
                        n_pend = hx.value;
                        n_nw   = 1'b1;
                    end
                end
            end
        end

        // Odd digit left at the end of the text forms a one-digit byte
        if (end_fire && !v_err && n_phase == cftp_pkg::PH_DATA && n_nw) begin
            v_put  = 1'b1;
            v_byte = {4'h0, n_pend};
            n_nw   = 1'b0;
        end

        // Store a byte; at most one per item
        if (v_put) begin
            if (r_bc >= cftp_pkg::MAX_DATA_BYTES) begin
                v_err = 1'b1;
            end else begin
                n_payload = r_payload | (64'(v_byte) << {r_bc[2:0], 3'b000});
                n_bc      = r_bc + 4'd1;
            end
        end

        n_err = v_err;
    end

    // Result fields for a text ending on this item
    always_comb begin
        res_err    = n_err || (n_phase == cftp_pkg::PH_ID);
        res_remote = (n_phase == cftp_pkg::PH_REMOTE) || (n_phase == cftp_pkg::PH_RLEN);
        res_ext    = (n_pc > cftp_pkg::STD_ID_CHARS) || (n_id > cftp_pkg::STD_ID_MAX);
        res_len    = res_remote ? n_rlen : n_bc;
        res_payload = res_remote ? 64'h0 : n_payload;
        res_id     = n_id;
        if (res_err) begin
            res_remote  = 1'b0;
            res_ext     = 1'b0;
            res_len     = 4'd0;
            res_payload = 64'h0;
            res_id      = 32'h0;
        end
    end

    // Parser state registers; back to the start state after the last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || end_fire) begin
            r_phase   <= cftp_pkg::PH_ID;
            r_id      <= 32'h0;
            r_pc      <= 4'd0;
            r_bc      <= 4'd0;
            r_payload <= 64'h0;
            r_pend    <= 4'h0;
            r_nw      <= 1'b0;
            r_tok     <= 1'b0;
            r_rlen    <= 4'd0;
            r_err     <= 1'b0;
        end else if (in_fire) begin
            r_phase   <= n_phase;
            r_id      <= n_id;
            r_pc      <= n_pc;
            r_bc      <= n_bc;
            r_payload <= n_payload;
            r_pend    <= n_pend;
            r_nw      <= n_nw;
            r_tok     <= n_tok;
            r_rlen    <= n_rlen;
            r_err     <= n_err;
        end
    end

    // Result register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (end_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (end_fire) begin
            r_out_data <= {4'h0, res_payload, res_len, res_id};
            r_out_user <= {res_remote, res_ext, !res_err};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
